[sv/sha_pkg.sv]
// package: constants, types and round functions for the sha-256 hasher
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadMark    = 8'h80;
  localparam logic [5:0]  LenPos     = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_FILL,
    ST_ROUND,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[i];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

endpackage
`default_nettype wire

[sv/sha_ram.sv]
// generic ram, one write port and one read port, with registered read
`timescale 1ns / 1ps
`default_nettype none
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/sha_compress.sv]
// 64-round compression engine, block words read from the buffer ram
`timescale 1ns / 1ps
`default_nettype none
module sha_compress (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [7:0][31:0] h_in,
  // block word fetch: address given in the cycle before the round that uses it
  output logic [3:0]            blk_addr,
  input  wire logic [31:0]      blk_word,
  output logic                  busy,
  output logic                  done,
  output logic [7:0][31:0]      h_out
);
  import sha_pkg::*;

  logic [5:0]   rnd_r, rnd_nxt;
  logic         run_r, run_nxt, done_r, done_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, hh_r;
  // schedule window: win_r[15] is the newest word
  logic [31:0]  win_r [16];
  logic [31:0]  w, s1, ch, t1, s0, mj, x15, x2;

  assign blk_addr = run_r ? rnd_r[3:0] + 4'd1 : 4'd0;
  assign busy     = run_r;
  assign done     = done_r;

  always_comb begin
    x15 = win_r[1];
    x2  = win_r[14];
    if (rnd_r[5:4] == 2'd0) begin
      w = blk_word;
    end else begin
      w = win_r[0] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + win_r[9]
        + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
    end
    s1 = ror32(e_r, 6) ^ ror32(e_r, 11) ^ ror32(e_r, 25);
    ch = (e_r & f_r) ^ (~e_r & g_r);
    t1 = hh_r + s1 + ch + round_k(rnd_r) + w;
    s0 = ror32(a_r, 2) ^ ror32(a_r, 13) ^ ror32(a_r, 22);
    mj = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    run_nxt  = run_r;
    rnd_nxt  = rnd_r;
    done_nxt = 1'b0;
    if (start && !run_r) begin
      run_nxt = 1'b1;
      rnd_nxt = '0;
    end else if (run_r) begin
      rnd_nxt = rnd_r + 6'd1;
      if (rnd_r == 6'(Rounds - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !run_r) begin
      a_r <= h_in[0]; b_r <= h_in[1]; c_r <= h_in[2]; d_r <= h_in[3];
      e_r <= h_in[4]; f_r <= h_in[5]; g_r <= h_in[6]; hh_r <= h_in[7];
    end else if (run_r) begin
      hh_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + s0 + mj;
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= w;
    end
  end

  always_comb begin
    h_out[0] = h_in[0] + a_r;
    h_out[1] = h_in[1] + b_r;
    h_out[2] = h_in[2] + c_r;
    h_out[3] = h_in[3] + d_r;
    h_out[4] = h_in[4] + e_r;
    h_out[5] = h_in[5] + f_r;
    h_out[6] = h_in[6] + g_r;
    h_out[7] = h_in[7] + hh_r;
  end
endmodule
`default_nettype wire

[sv/sha256_byte_stream_hasher_core.sv]
// top level: byte stream in, sha-256 digest words out
//
// in_tdata[7:0] carries one message byte; in_tuser = {end_of_message,
// byte_present}. a request is taken when in_tvalid and in_tready are high.
// bytes gather into 32-bit words; each full word goes to a 16x32 block ram.
// ordinary bytes may come back to back.
// the 64th byte starts the compression: 64 rounds at one per cycle, then
// a fold into the hash; in_tready stays low until the fold is done, so no
// byte is taken while a block is being compressed.
// an end request pads (0x80, zeros, big-endian bit length) one word per
// cycle, then compresses and emits the digest; when the padding spills
// into a second block, that block is padded and compressed as well, and
// when the end request also completes a block, that block goes first.
// eight words follow on out_* (index 0 first, tlast on word 7), one per
// cycle while out_tready is high; out_tready low holds the current word.
// in_tready stays low until the last word leaves.
// reset (synchronous, rst_n low) restores the initial hash, clears length
// and fill count; buffer contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,  // data_byte
  input  wire logic [1:0]  in_tuser,  // byte_present, end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata, // digest_word[31:0], word_index[34:32], zero fill
  output logic             out_tlast  // last_word
);
  import sha_pkg::*;

  state_t            st_r, st_nxt;
  logic [5:0]        fill_r, fill_nxt;
  logic [63:0]       len_r, len_nxt;
  logic [7:0][31:0]  h_r;
  logic [7:0][31:0]  h_fold;
  logic [2:0]        oidx_r, oidx_nxt;
  logic [4:0]        wp_r, wp_nxt;
  logic              spill_r, spill_nxt;
  logic              pad_r, pad_nxt;
  logic              eom_r, eom_nxt;
  logic [31:0]       wacc_r;
  logic              byte_take;
  logic              h_load, h_reset;
  logic              cmp_start, cmp_busy, cmp_done;
  logic [3:0]        rd_addr;
  logic [31:0]       rd_word;
  logic              wr_en;
  logic [3:0]        wr_addr;
  logic [31:0]       wr_data;
  logic [31:0]       pad_word;
  logic              acc;

  sha_ram #(.Width(32), .Depth(16)) u_buf (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rd_word)
  );

  sha_compress u_cmp (
    .clk(clk), .rst_n(rst_n), .start(cmp_start), .h_in(h_r),
    .blk_addr(rd_addr), .blk_word(rd_word), .busy(cmp_busy), .done(cmp_done),
    .h_out(h_fold)
  );

  assign acc = in_tvalid && in_tready;

  // partial word: bytes already taken, then the pad mark, then zeros
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < fill_r[1:0]) begin
        pad_word[31 - 8*j -: 8] = wacc_r[31 - 8*j -: 8];
      end else if (2'(j) == fill_r[1:0]) begin
        pad_word[31 - 8*j -: 8] = PadMark;
      end else begin
        pad_word[31 - 8*j -: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    st_nxt     = st_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    oidx_nxt   = oidx_r;
    wp_nxt     = wp_r;
    spill_nxt  = spill_r;
    pad_nxt    = pad_r;
    eom_nxt    = eom_r;
    byte_take  = 1'b0;
    cmp_start  = 1'b0;
    h_load     = 1'b0;
    h_reset    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = fill_r[5:2];
    wr_data    = {wacc_r[31:8], in_tdata};
    in_tready  = (st_r == ST_IDLE);
    out_tvalid = (st_r == ST_EMIT);
    case (st_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_tuser[0]) begin
            byte_take = 1'b1;
            fill_nxt  = fill_r + 6'd1;
            len_nxt   = len_r + 64'd8;
            if (fill_r[1:0] == 2'd3) begin
              wr_en = 1'b1;
            end
            if (fill_r == 6'd63) begin
              cmp_start = 1'b1;
              eom_nxt   = in_tuser[1];
              st_nxt    = ST_ROUND;
            end else if (in_tuser[1]) begin
              st_nxt = ST_PAD;
            end
          end else if (in_tuser[1]) begin
            st_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wr_en     = 1'b1;
        wr_data   = pad_word;
        wp_nxt    = {1'b0, fill_r[5:2]} + 5'd1;
        // no room for the length after the pad mark
        spill_nxt = (fill_r >= LenPos);
        pad_nxt   = 1'b1;
        eom_nxt   = 1'b0;
        st_nxt    = ST_FILL;
      end
      ST_FILL: begin
        if (wp_r == 5'(BlockWords)) begin
          cmp_start = 1'b1;
          st_nxt    = ST_ROUND;
        end else begin
          wr_en   = 1'b1;
          wr_addr = wp_r[3:0];
          if (spill_r) begin
            wr_data = '0;
          end else if (wp_r[3:0] == LenPos[5:2]) begin
            wr_data = len_r[63:32];
          end else if (wp_r[3:0] == LenPos[5:2] + 4'd1) begin
            wr_data = len_r[31:0];
          end else begin
            wr_data = '0;
          end
          wp_nxt = wp_r + 5'd1;
        end
      end
      ST_ROUND: begin
        if (cmp_done) begin
          h_load = 1'b1;
          if (!pad_r) begin
            st_nxt = eom_r ? ST_PAD : ST_IDLE;
          end else if (spill_r) begin
            spill_nxt = 1'b0;
            wp_nxt    = '0;
            st_nxt    = ST_FILL;
          end else begin
            oidx_nxt = '0;
            st_nxt   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_tready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            h_reset  = 1'b1;
            len_nxt  = '0;
            fill_nxt = '0;
            pad_nxt  = 1'b0;
            st_nxt   = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; fill_r <= '0; len_r <= '0; oidx_r <= '0;
      wp_r <= '0; spill_r <= 1'b0; pad_r <= 1'b0; eom_r <= 1'b0;
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; len_r <= len_nxt; oidx_r <= oidx_nxt;
      wp_r <= wp_nxt; spill_r <= spill_nxt; pad_r <= pad_nxt; eom_r <= eom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || h_reset) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= init_h(3'(i));
      end
    end else if (h_load) begin
      h_r <= h_fold;
    end
    if (byte_take) begin
      wacc_r[31 - 8*fill_r[1:0] -: 8] <= in_tdata;
    end
  end

  assign out_tdata = {5'd0, oidx_r, h_r[oidx_r]};
  assign out_tlast = (oidx_r == 3'd7);

  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while emitting");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("digest word changed while stalled");
  a_tlast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("emit past last word");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_busy |-> (!in_tready && !out_tvalid)) else $error("busy accept");
endmodule
`default_nettype wire

[dv/sha256_digest_checker.sv]
// checker: watches the byte and digest channels, predicts sha-256 digests and compares
`timescale 1ns / 1ps
`default_nettype none
module sha256_digest_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending_words,
  output int               digest_count
);
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] HINIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [7:0]   blk [64];
  int           fill;
  logic [63:0]  bit_len;
  logic [31:0]  hash [8];
  digest_word_t digest_q [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    v = hash;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash[i] += v[i];
  endtask

  task automatic absorb_request(logic [7:0] b, logic present, logic eom);
    digest_word_t d;
    if (present) begin
      blk[fill] = b;
      fill++;
      bit_len += 64'd8;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (eom) begin
      blk[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        while (fill < 64) blk[fill++] = 8'h00;
        compress();
        fill = 0;
      end
      while (fill < 56) blk[fill++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        d.word = hash[i];
        d.index = 3'(i);
        d.last = (i == 7);
        digest_q = {digest_q, d};
      end
      hash = HINIT;
      fill = 0;
      bit_len = '0;
    end
  endtask

  always @(posedge clk) begin
    digest_word_t e;
    if (!rst_n) begin
      hash = HINIT;
      fill = 0;
      bit_len = '0;
      digest_q.delete();
      fail_count <= 0;
      digest_count <= 0;
    end else begin
      if (in_tvalid && in_tready) absorb_request(in_tdata, in_tuser[0], in_tuser[1]);
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected digest word %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = digest_q.pop_front();
          if (out_tdata[31:0] !== e.word || out_tdata[34:32] !== e.index ||
              out_tdata[39:35] !== 5'd0 || out_tlast !== e.last) begin
            if (fail_count < 10)
              $display("digest mismatch: exp word %h idx %0d last %b, got %h idx %0d last %b",
                       e.word, e.index, e.last, out_tdata[31:0], out_tdata[34:32], out_tlast);
            fail_count <= fail_count + 1;
          end
          if (e.last) digest_count <= digest_count + 1;
        end
      end
    end
    pending_words <= digest_q.size();
  end
endmodule
`default_nettype wire

[dv/tb_sha256_byte_stream_hasher_core.sv]
// testbench top: byte stream stimulus, digest sink and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_sha256_byte_stream_hasher_core;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // data_byte
  logic [1:0]  in_tuser = '0;   // byte_present, end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // digest_word, word_index, zero fill
  logic        out_tlast;
  int          fail_count, pending_words, digest_count;
  int          request_count = 0;
  bit          long_hold = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sha256_byte_stream_hasher_core dut (.*);

  sha256_digest_checker u_checker (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  // one request, held until taken, with a random gap after it when gaps is set
  task automatic send_request(logic [7:0] b, logic present, logic eom, bit gaps);
    int g;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= {eom, present};
    do @(posedge clk); while (!in_tready);
    request_count++;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_message(int len, bit gaps);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_request(8'($urandom), 1'b0, 1'b0, gaps);
      send_request(8'($urandom), 1'b1, (i == len - 1), gaps);
    end
    if (len == 0) send_request(8'($urandom), 1'b0, 1'b1, gaps);
  endtask

  // receiver stalls: short random ones, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    int len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty message, byte extremes, idle requests
    send_request(8'h00, 1'b0, 1'b1, 1'b0);
    send_request(8'h61, 1'b1, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0, 1'b0);
    send_request(8'h62, 1'b1, 1'b0, 1'b0);
    send_request(8'h63, 1'b1, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b1, 1'b0);
    send_request(8'haa, 1'b0, 1'b0, 1'b0);
    send_request(8'h55, 1'b1, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1, 1'b0);
    // sender pause until every digest word has come
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    // pad spills into a second block, pad just fits, exact block, block plus end-only item
    send_message(56, 1'b1);
    send_message(55, 1'b1);
    send_message(64, 1'b1);
    for (int i = 0; i < 64; i++) send_request(8'($urandom), 1'b1, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b1, 1'b1);
    // long receiver hold-off while short messages keep coming
    long_hold = 1'b1;
    for (int i = 0; i < 6; i++) send_message($urandom_range(0, 3), 1'b0);
    while (request_count < 400) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      if (request_count + len > 410) len = 410 - request_count;
      send_message(len, 1'b1);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d byte/end requests, checked %0d digests incl. empty and spill padding",
             request_count, digest_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
sv/sha_pkg.sv
sv/sha_ram.sv
sv/sha_compress.sv
sv/sha256_byte_stream_hasher_core.sv
dv/sha256_digest_checker.sv
dv/tb_sha256_byte_stream_hasher_core.sv
